/* sv/pbr_pkg.sv */
// pbr_pkg: shared types, codes and helpers of the polynomial bisection root finder
// depends on nothing; imported by every other file of the block

package pbr_pkg;

	localparam int DATA_W        = 32;
	localparam int COEF_REGS     = 5;
	localparam int COEF_IDX_W    = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int DEG_W         = 3;
	localparam int TOL_W         = 31;
	localparam int STATUS_W      = 3;
	localparam int ITER_W        = 6;

	localparam int DEF_MAX_DEGREE = 4;
	localparam int DEF_MAX_ITER   = 40;
	localparam int DEF_FRAC_BITS  = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TOL       = 3'd6;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [STATUS_W-1:0] {
		STAT_WIDTH      = 3'd0,
		STAT_ZERO_START = 3'd1,
		STAT_ZERO_END   = 3'd2,
		STAT_ZERO_MID   = 3'd3,
		STAT_NO_CHANGE  = 3'd4
	} status_t;

	// evaluation point of one horner pass
	typedef enum logic [1:0] {
		PT_MID   = 2'd0,
		PT_END   = 2'd1,
		PT_START = 2'd2
	} pt_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MID,
		S_INIT,
		S_MUL,
		S_ADD,
		S_DECIDE,
		S_FIN
	} state_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} sgn_t;

	typedef struct packed {
		logic                  load_in;
		logic                  calc_mid;
		logic                  eval_init;
		logic                  save_sign;
		logic                  mul;
		logic                  add;
		logic                  decide;
		logic                  load_out;
		pt_t                   pt;
		logic [COEF_IDX_W-1:0] cidx;
	} cmd_t;

	typedef struct packed {
		logic                  stop;
		logic [COEF_IDX_W-1:0] eff_deg;
	} stat_t;

	function automatic sgn_t sign_of(input logic signed [DATA_W-1:0] v);
		sgn_t s;
		s.neg  = v[DATA_W-1];
		s.zero = (v == '0);
		return s;
	endfunction

	function automatic logic opposite(input sgn_t a, input sgn_t b);
		return !a.zero && !b.zero && (a.neg != b.neg);
	endfunction

	// saturating add of two signed words
	function automatic logic signed [DATA_W-1:0] sat_add(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1]) begin
			return s[DATA_W] ? SAT_MIN : SAT_MAX;
		end
		return s[DATA_W-1:0];
	endfunction

endpackage

/* sv/pbr_if.sv */
// pbr_if: valid/ready channel interfaces for the interval request and the root result
// depends on pbr_pkg

interface pbr_in_if import pbr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] interval_start;
	logic signed [DATA_W-1:0] interval_end;

	modport source (output valid, output interval_start, output interval_end, input ready);
	modport sink   (input valid, input interval_start, input interval_end, output ready);
endinterface

interface pbr_out_if import pbr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] root;
	logic [STATUS_W-1:0]      status;
	logic [ITER_W-1:0]        iterations;

	modport source (output valid, output root, output status, output iterations, input ready);
	modport sink   (input valid, input root, input status, input iterations, output ready);
endinterface

/* sv/polynomial_bisection_root.sv */
// polynomial_bisection_root: top level of the fixed-point bisection root finder
// depends on pbr_pkg, pbr_if, pbr_dp and pbr_ctrl
//
// channel   dir  payload                              handshake
// req       in   interval_start, interval_end (Q16)   valid/ready
// rsp       out  root (Q16), status, iterations       valid/ready
// cfg       in   cfg_index, cfg_data                  cfg_we, no wait
//
// one item at a time; a pass computes the midpoint, runs three horner evaluations
// of d multiply/add steps each on one shared 32x32 multiplier for effective
// degree d, and ends in a decision; an item takes up to MAX_ITER passes
// a finished result sits in the output register; the next request is taken
// while it waits, and the following result stalls only if it is still not taken
// arst_n clears the sequencer and loads register reset values

module polynomial_bisection_root import pbr_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int MAX_ITER   = DEF_MAX_ITER,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	pbr_in_if.sink               req,
	pbr_out_if.source            rsp
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: pass counter, point select, coefficient index, result valid
	pbr_ctrl #(
		.MAX_ITER (MAX_ITER)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.iterations (rsp.iterations),
		.cmd        (cmd),
		.stat       (stat)
	);

	// datapath: interval, horner unit, sign tests, result payload
	pbr_dp #(
		.MAX_DEGREE (MAX_DEGREE),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.interval_start (req.interval_start),
		.interval_end   (req.interval_end),
		.cmd            (cmd),
		.stat           (stat),
		.root           (rsp.root),
		.status         (rsp.status)
	);

	// a transfer on req starts the search, so ready drops for the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a search was starting");

	// a result only appears out of a running search
	a_rsp_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result raised without a search");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status <= STAT_NO_CHANGE)
		else $error("undefined status code on result");

	// the load strobes of the horner unit never coincide
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.calc_mid, cmd.eval_init, cmd.mul, cmd.add, cmd.decide}))
		else $error("conflicting datapath commands");

endmodule

/* sv/pbr_dp.sv */
// pbr_dp: datapath of the bisection root finder; config registers, interval,
// horner multiply/accumulate unit, sign tests and result registers; uses pbr_pkg

module pbr_dp import pbr_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic signed [DATA_W-1:0] interval_start,
	input  logic signed [DATA_W-1:0] interval_end,
	input  cmd_t                     cmd,
	output stat_t                    stat,
	output logic signed [DATA_W-1:0] root,
	output logic [STATUS_W-1:0]      status
);

	localparam int DEG_LIM = (MAX_DEGREE < COEF_REGS - 1) ? MAX_DEGREE : COEF_REGS - 1;
	localparam logic [DEG_W-1:0] DEG_LIM_V = DEG_W'(DEG_LIM);

	logic signed [DATA_W-1:0]   coef_q [COEF_REGS];
	logic [DEG_W-1:0]           deg_q;
	logic [TOL_W-1:0]           tol_q;

	logic signed [DATA_W-1:0]   xs_q, xe_q, xm_q, x_q, acc_q;
	logic signed [2*DATA_W-1:0] prod_q;
	sgn_t                       sgn_m_q, sgn_e_q;
	logic signed [DATA_W-1:0]   res_root_q, root_q;
	status_t                    res_status_q, status_q;

	logic [DEG_W-1:0]           eff_deg;
	logic signed [DATA_W:0]     mid_sum;
	logic signed [2*DATA_W-1:0] shifted;
	logic signed [DATA_W-1:0]   prod_sat;
	logic signed [DATA_W-1:0]   acc_nxt;

	sgn_t                       ss;
	logic                       brk;
	status_t                    code;
	logic signed [DATA_W-1:0]   brk_root, nxs, nxe;
	logic signed [DATA_W:0]     width;
	logic                       narrow;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_REGS; i++) begin
				coef_q[i] <= '0;
			end
			deg_q <= DEG_W'(4);
			tol_q <= TOL_W'(1);
		end else if (cfg_we) begin
			if (cfg_index <= REG_COEF_LAST) begin
				coef_q[cfg_index] <= cfg_data;
			end else if (cfg_index == REG_DEGREE) begin
				deg_q <= cfg_data[DEG_W-1:0];
			end else if (cfg_index == REG_TOL) begin
				tol_q <= cfg_data[TOL_W-1:0];
			end
		end
	end

	always_comb begin
		if (deg_q == '0) begin
			eff_deg = DEG_W'(1);
		end else if (deg_q > DEG_LIM_V) begin
			eff_deg = DEG_LIM_V;
		end else begin
			eff_deg = deg_q;
		end
	end

	// floor midpoint from the exact sum
	assign mid_sum = {xs_q[DATA_W-1], xs_q} + {xe_q[DATA_W-1], xe_q};

	// horner step: floor shift, saturate, saturating add of coefficient
	assign shifted = prod_q >>> FRAC_BITS;

	always_comb begin
		if ((&shifted[2*DATA_W-1:DATA_W-1]) || !(|shifted[2*DATA_W-1:DATA_W-1])) begin
			prod_sat = shifted[DATA_W-1:0];
		end else begin
			prod_sat = shifted[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
		end
		acc_nxt = sat_add(prod_sat, coef_q[cmd.cidx]);
	end

	// sign tests of one pass; acc holds the start value here
	always_comb begin
		ss       = sign_of(acc_q);
		brk      = 1'b0;
		code     = STAT_WIDTH;
		brk_root = xm_q;
		nxs      = xs_q;
		nxe      = xe_q;
		if (opposite(ss, sgn_m_q)) begin
			nxe = xm_q;
		end else if (opposite(sgn_m_q, sgn_e_q)) begin
			nxs = xm_q;
		end else begin
			brk = 1'b1;
			if (ss.zero) begin
				code     = STAT_ZERO_START;
				brk_root = xs_q;
			end else if (sgn_e_q.zero) begin
				code     = STAT_ZERO_END;
				brk_root = xe_q;
			end else if (sgn_m_q.zero) begin
				code = STAT_ZERO_MID;
			end else begin
				code = STAT_NO_CHANGE;
			end
		end
		width  = {nxe[DATA_W-1], nxe} - {nxs[DATA_W-1], nxs};
		narrow = width < $signed({2'b00, tol_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			xs_q <= interval_start;
			xe_q <= interval_end;
		end
		if (cmd.calc_mid) begin
			xm_q <= mid_sum[DATA_W:1];
		end
		if (cmd.save_sign) begin
			if (cmd.pt == PT_END) begin
				sgn_m_q <= sign_of(acc_q);
			end else begin
				sgn_e_q <= sign_of(acc_q);
			end
		end
		if (cmd.eval_init) begin
			acc_q <= coef_q[0];
			case (cmd.pt)
				PT_MID:   x_q <= xm_q;
				PT_END:   x_q <= xe_q;
				PT_START: x_q <= xs_q;
				default:  x_q <= xm_q;
			endcase
		end else if (cmd.add) begin
			acc_q <= acc_nxt;
		end
		if (cmd.mul) begin
			prod_q <= acc_q * x_q;
		end
		if (cmd.decide) begin
			xs_q         <= nxs;
			xe_q         <= nxe;
			res_root_q   <= brk ? brk_root : xm_q;
			res_status_q <= brk ? code : STAT_WIDTH;
		end
		if (cmd.load_out) begin
			root_q   <= res_root_q;
			status_q <= res_status_q;
		end
	end

	assign stat.stop    = brk || narrow;
	assign stat.eff_deg = eff_deg;
	assign root         = root_q;
	assign status       = status_q;

endmodule

/* sv/pbr_ctrl.sv */
// pbr_ctrl: sequencer of the bisection root finder; pass, point and coefficient
// counters, handshakes and result valid; uses pbr_pkg

module pbr_ctrl import pbr_pkg::*; #(
	parameter int MAX_ITER = DEF_MAX_ITER
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [ITER_W-1:0] iterations,
	output cmd_t              cmd,
	input  stat_t             stat
);

	localparam int PASS_W = $clog2(MAX_ITER + 1);
	localparam logic [PASS_W-1:0] PASS_CAP = PASS_W'(MAX_ITER);

	state_t                state_q, state_d;
	logic [PASS_W-1:0]     pass_q, pass_d;
	pt_t                   pt_q, pt_d;
	logic [COEF_IDX_W-1:0] k_q, k_d;
	logic                  out_valid_q, out_valid_d;
	logic [ITER_W-1:0]     iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= '0;
			pt_q        <= PT_MID;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pass_q      <= pass_d;
			pt_q        <= pt_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			iter_q <= ITER_W'(pass_q);
		end
	end

	always_comb begin
		state_d     = state_q;
		pass_d      = pass_q;
		pt_d        = pt_q;
		k_d         = k_q;
		out_valid_d = out_valid_q && !rsp_ready;
		req_ready   = 1'b0;
		cmd         = '0;
		cmd.pt      = pt_q;
		cmd.cidx    = k_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					pass_d      = '0;
					state_d     = S_MID;
				end
			end
			S_MID: begin
				cmd.calc_mid = 1'b1;
				pass_d       = pass_q + 1'b1;
				pt_d         = PT_MID;
				state_d      = S_INIT;
			end
			S_INIT: begin
				cmd.eval_init = 1'b1;
				// previous point's value is still in the accumulator
				cmd.save_sign = (pt_q != PT_MID);
				k_d           = COEF_IDX_W'(1);
				state_d       = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				if (k_q == stat.eff_deg) begin
					case (pt_q)
						PT_MID: begin
							pt_d    = PT_END;
							state_d = S_INIT;
						end
						PT_END: begin
							pt_d    = PT_START;
							state_d = S_INIT;
						end
						default: begin
							state_d = S_DECIDE;
						end
					endcase
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (stat.stop || pass_q >= PASS_CAP) begin
					state_d = S_FIN;
				end else begin
					state_d = S_MID;
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid  = out_valid_q;
	assign iterations = iter_q;

endmodule
